@@ rtl/diag_request_responder_unit_assert.svh @@
// Assertion macros for the responder top level.
`ifndef DIAG_REQUEST_RESPONDER_UNIT_ASSERT_SVH
`define DIAG_REQUEST_RESPONDER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DRR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/drr_pkg.sv @@
package drr_pkg;

  // Service identifiers and response codes
  localparam logic [7:0] SID_SESSION  = 8'h10;
  localparam logic [7:0] SID_READ     = 8'h22;
  localparam logic [7:0] SID_NEGATIVE = 8'h7F;
  localparam logic [7:0] RSP_SESSION  = 8'h50;
  localparam logic [7:0] RSP_READ     = 8'h62;

  // Negative response codes
  localparam logic [7:0] NRC_GENERAL_REJECT  = 8'h10;
  localparam logic [7:0] NRC_SERVICE_NOT_SUP = 8'h11;
  localparam logic [7:0] NRC_SUBFUNC_NOT_SUP = 8'h12;
  localparam logic [7:0] NRC_BAD_LENGTH      = 8'h13;
  localparam logic [7:0] NRC_RESP_TOO_LONG   = 8'h14;
  localparam logic [7:0] NRC_OUT_OF_RANGE    = 8'h31;

  // Sessions
  localparam logic [6:0] SESS_DEFAULT  = 7'd1;
  localparam logic [6:0] SESS_EXTENDED = 7'd3;

  // Lengths
  localparam logic [15:0] LEN_SESSION_REQ = 16'd2;
  localparam logic [15:0] LEN_READ_REQ    = 16'd3;
  localparam logic [15:0] LEN_NEG_RSP     = 16'd3;
  localparam logic [15:0] LEN_SESSION_RSP = 16'd6;
  localparam logic [15:0] LEN_READ_HDR    = 16'd3;

  // Register reset values
  localparam logic [15:0] P2_RESET      = 16'd50;
  localparam logic [15:0] P2_STAR_RESET = 16'd500;

  localparam int RESP_MAX   = 6;
  localparam int CNT_W      = $clog2(RESP_MAX + 1);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_NEG  = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_READ = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_SESS = CNT_W'(6);

  typedef enum logic [1:0] {
    CFG_PROVIDER_EN = 2'd0,
    CFG_P2_SERVER   = 2'd1,
    CFG_P2_STAR     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_NO_RESP   = 2'd1,
    RES_TOO_SMALL = 2'd2
  } res_code_e;

  typedef enum logic [1:0] {
    PST_OK        = 2'd0,
    PST_NOT_FOUND = 2'd1,
    PST_TOO_LONG  = 2'd2,
    PST_FAILURE   = 2'd3
  } prov_status_e;

  typedef struct packed {
    logic [7:0]  request_sid;
    logic [7:0]  request_byte1;
    logic [7:0]  request_byte2;
    logic [15:0] request_length;
    logic [15:0] resp_room;
    logic [1:0]  provider_status;
    logic [15:0] provider_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  resp_byte;
    logic        byte_valid;
    logic        resp_last;
    logic [1:0]  result_code;
    logic [15:0] response_length;
    logic [6:0]  active_session;
  } out_item_t;

  // Classified request, handed from front to back through the queue
  typedef struct packed {
    logic [RESP_MAX-1:0][7:0] resp_bytes;
    logic [CNT_W-1:0]         count;
    logic                     byte_valid;
    res_code_e                code;
    logic [15:0]              len;
    logic [6:0]               session;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ rtl/drr_front.sv @@
module drr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  drr_pkg::in_item_t in_item_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  drr_pkg::fifo_stat_t fifo_stat_i,
  output logic             push_o,
  output drr_pkg::desc_t   desc_o
);
  import drr_pkg::*;

  logic        prov_en_q;
  logic [15:0] p2_q;
  logic [15:0] p2_star_q;
  logic [6:0]  session_q, session_d;
  logic [6:0]  sub;
  logic        sess_ok;

  function automatic desc_t f_status(res_code_e code, logic [6:0] sess);
    desc_t d;
    d            = '0;
    d.count      = CNT_ONE;
    d.byte_valid = 1'b0;
    d.code       = code;
    d.len        = '0;
    d.session    = sess;
    return d;
  endfunction

  function automatic desc_t f_neg(logic [7:0] sid, logic [7:0] nrc, logic [15:0] cap,
                                  logic [6:0] sess);
    desc_t d;
    if (cap < LEN_NEG_RSP) begin
      d = f_status(RES_TOO_SMALL, sess);
    end else begin
      d               = '0;
      d.resp_bytes[0] = SID_NEGATIVE;
      d.resp_bytes[1] = sid;
      d.resp_bytes[2] = nrc;
      d.count         = CNT_NEG;
      d.byte_valid    = 1'b1;
      d.code          = RES_OK;
      d.len           = LEN_NEG_RSP;
      d.session       = sess;
    end
    return d;
  endfunction

  assign in_ready_o = !fifo_stat_i.full;
  assign push_o     = in_valid_i && !fifo_stat_i.full;

  assign sub     = in_item_i.request_byte1[6:0];
  assign sess_ok = (sub == SESS_DEFAULT) || (sub == SESS_EXTENDED);

  // Session switches only on a well-formed session request
  always_comb begin
    session_d = session_q;
    if (in_item_i.request_length != '0 && in_item_i.request_sid == SID_SESSION &&
        in_item_i.request_length == LEN_SESSION_REQ && sess_ok) begin
      session_d = sub;
    end
  end

  always_comb begin
    desc_o = f_status(RES_NO_RESP, session_d);
    priority if (in_item_i.request_length == '0) begin
      desc_o = f_status(RES_NO_RESP, session_d);
    end else if (in_item_i.request_sid == SID_SESSION) begin
      priority if (in_item_i.request_length != LEN_SESSION_REQ) begin
        desc_o = f_neg(SID_SESSION, NRC_BAD_LENGTH, in_item_i.resp_room, session_d);
      end else if (!sess_ok) begin
        desc_o = f_neg(SID_SESSION, NRC_SUBFUNC_NOT_SUP, in_item_i.resp_room,
                       session_d);
      end else if (in_item_i.request_byte1[7]) begin
        desc_o = f_status(RES_NO_RESP, session_d);
      end else if (in_item_i.resp_room < LEN_SESSION_RSP) begin
        desc_o = f_status(RES_TOO_SMALL, session_d);
      end else begin
        desc_o.resp_bytes[0] = RSP_SESSION;
        desc_o.resp_bytes[1] = {1'b0, sub};
        desc_o.resp_bytes[2] = p2_q[15:8];
        desc_o.resp_bytes[3] = p2_q[7:0];
        desc_o.resp_bytes[4] = p2_star_q[15:8];
        desc_o.resp_bytes[5] = p2_star_q[7:0];
        desc_o.count         = CNT_SESS;
        desc_o.byte_valid    = 1'b1;
        desc_o.code          = RES_OK;
        desc_o.len           = LEN_SESSION_RSP;
      end
    end else if (in_item_i.request_sid == SID_READ) begin
      priority if (in_item_i.resp_room < LEN_NEG_RSP) begin
        desc_o = f_status(RES_TOO_SMALL, session_d);
      end else if (in_item_i.request_length != LEN_READ_REQ) begin
        desc_o = f_neg(SID_READ, NRC_BAD_LENGTH, in_item_i.resp_room, session_d);
      end else if (!prov_en_q) begin
        desc_o = f_neg(SID_READ, NRC_SERVICE_NOT_SUP, in_item_i.resp_room,
                       session_d);
      end else begin
        unique case (prov_status_e'(in_item_i.provider_status))
          PST_OK: begin
            desc_o               = '0;
            desc_o.resp_bytes[0] = RSP_READ;
            desc_o.resp_bytes[1] = in_item_i.request_byte1;
            desc_o.resp_bytes[2] = in_item_i.request_byte2;
            desc_o.count         = CNT_READ;
            desc_o.byte_valid    = 1'b1;
            desc_o.code          = RES_OK;
            desc_o.len           = LEN_READ_HDR + in_item_i.provider_length;
            desc_o.session       = session_d;
          end
          PST_NOT_FOUND: desc_o = f_neg(SID_READ, NRC_OUT_OF_RANGE,
                                        in_item_i.resp_room, session_d);
          PST_TOO_LONG:  desc_o = f_neg(SID_READ, NRC_RESP_TOO_LONG,
                                        in_item_i.resp_room, session_d);
          default:       desc_o = f_neg(SID_READ, NRC_GENERAL_REJECT,
                                        in_item_i.resp_room, session_d);
        endcase
      end
    end else begin
      desc_o = f_neg(in_item_i.request_sid, NRC_SERVICE_NOT_SUP,
                     in_item_i.resp_room, session_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prov_en_q <= 1'b0;
      p2_q      <= P2_RESET;
      p2_star_q <= P2_STAR_RESET;
      session_q <= SESS_DEFAULT;
    end else begin
      if (push_o) begin
        session_q <= session_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PROVIDER_EN: prov_en_q <= cfg_data_i[0];
          CFG_P2_SERVER:   p2_q      <= cfg_data_i;
          CFG_P2_STAR:     p2_star_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/drr_fifo.sv @@
module drr_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  drr_pkg::desc_t      wdata_i,
  input  logic                pop_i,
  output drr_pkg::desc_t      rdata_o,
  output drr_pkg::fifo_stat_t stat_o
);
  import drr_pkg::*;

  desc_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/drr_back.sv @@
module drr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  drr_pkg::desc_t      head_i,
  input  drr_pkg::fifo_stat_t fifo_stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output drr_pkg::out_item_t  out_item_o
);
  import drr_pkg::*;

  logic [CNT_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             advance, load, is_last;

  // Free the output register when empty or when its item is taken
  assign advance = !out_valid_q || out_ready_i;
  assign load    = advance && !fifo_stat_i.empty;
  assign is_last = (idx_q == head_i.count - CNT_ONE);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_valid_d           = 1'b1;
      out_d.resp_byte       = head_i.resp_bytes[idx_q];
      out_d.byte_valid      = head_i.byte_valid;
      out_d.resp_last       = is_last;
      out_d.result_code     = head_i.code;
      out_d.response_length = head_i.len;
      out_d.active_session  = head_i.session;
      idx_d                 = is_last ? '0 : idx_q + CNT_ONE;
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ rtl/diag_request_responder_unit.sv @@
// Diagnostic request responder (session control 0x10 and read by identifier
// 0x22). Each accepted request item yields one to six result items: either
// the response header bytes, one per item with resp_last on the final one,
// or a single status-only item (byte_valid low) for "no response" or
// "buffer too small". The front stage classifies a request in the cycle it
// is accepted, updates the active session and pushes a descriptor into a
// two-entry queue; it accepts one request per cycle while the queue has
// room. The back stage streams one result item per cycle from the queue
// head into an output register while the output is taken; a request takes
// one output transfer per result item (1, 3 or 6), and the serial output
// port sets the sustained rate. The first result item is registered in the
// queue entry, then in the output register. Configuration writes
// (provider enable, P2, P2*) take effect at once and must be made while
// no request is in flight; an index beyond the register list is ignored.
`include "diag_request_responder_unit_assert.svh"

module diag_request_responder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  drr_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output drr_pkg::out_item_t  out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import drr_pkg::*;

  // Handoff between front and back
  desc_t      push_desc;
  desc_t      head_desc;
  logic       push;
  logic       pop;
  fifo_stat_t fifo_stat;

  // Accept and classify requests, hold session and registers
  drr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  // Decouple classification from byte streaming
  drr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_desc),
    .pop_i   (pop),
    .rdata_o (head_desc),
    .stat_o  (fifo_stat)
  );

  // Stream result items, one per cycle while the output is taken
  drr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_desc),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Status-only items close their request and carry no length
  `DRR_ASSERT_IMPL(a_status_only_last, clk_i, rst_ni,
    out_valid_o && !out_item_o.byte_valid,
    out_item_o.resp_last && out_item_o.response_length == '0,
    "status-only item not last or with length")

  // Byte items always report success
  `DRR_ASSERT_IMPL(a_bytes_ok, clk_i, rst_ni,
    out_valid_o && out_item_o.byte_valid,
    out_item_o.result_code == RES_OK,
    "byte item with error code")

  // Session is only ever default or extended
  `DRR_ASSERT_IMPL(a_session_legal, clk_i, rst_ni,
    out_valid_o,
    out_item_o.active_session == SESS_DEFAULT ||
    out_item_o.active_session == SESS_EXTENDED,
    "illegal session on output")

  // Queue head is taken as its last item is loaded into the output register
  `DRR_ASSERT_NEXT(a_pop_emits_last, clk_i, rst_ni,
    pop,
    out_valid_o && out_item_o.resp_last,
    "queue popped without a last item")

endmodule
